// File: rtl/core/assert_macros.svh
// Assertion macros shared by the hit-count table RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset
`define PHC_ASSERT(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) \
    else $error("assertion failed");
// Condition in one cycle implies a condition in the next
`define PHC_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define PHC_ASSERT(lbl, clk_s, rst_s, expr)
`define PHC_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post)
`endif
`endif

// File: rtl/core/phc_pkg.sv
// Package for the pixel hit-count table: sizes, codes, control structs.
// No dependencies.
package phc_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int MASK_W   = 9;
  localparam int CW       = (OCC_W > MASK_W) ? OCC_W : MASK_W;
  localparam int KEY_W    = 64;
  localparam int CNT_W    = 32;
  localparam int BIT_W    = $clog2(CNT_W);

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_TOP  = 2'd2;
  localparam logic [1:0] CMD_SUM  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOOKUP,
    MODE_TOP,
    MODE_GE,
    MODE_FINAL
  } scan_mode_t;

  typedef struct packed {
    logic       load_item;
    logic       start;
    scan_mode_t mode;
    logic       scan;
    logic       commit_bit;
    logic       add_write;
    logic       mul;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       bit_zero;
    logic       sum_over;
    logic       mask_zero;
    logic [1:0] cmd;
    logic       out_busy;
  } dp_sts_t;

endpackage

// File: rtl/core/phc_if.sv
// Valid/ready channel interfaces for items into and results out of the table.
// Depends on phc_pkg for field widths.
interface phc_in_if import phc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [KEY_W-1:0] pixel_key;
  logic [CNT_W-1:0] hit_count;
  logic [MASK_W-1:0] mask_count;
  modport source (output valid, cmd, pixel_key, hit_count, mask_count, input ready);
  modport sink   (input valid, cmd, pixel_key, hit_count, mask_count, output ready);
endinterface

interface phc_out_if import phc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count_out;
  logic [KEY_W-1:0] key_out;
  logic [1:0]       status;
  modport source (output valid, count_out, key_out, status, input ready);
  modport sink   (input valid, count_out, key_out, status, output ready);
endinterface

// File: rtl/core/phc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module phc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/phc_dp.sv
// Datapath of the hit-count table: entry RAMs, scan counter, accumulators, result.
// Depends on phc_pkg, phc_ram and assert_macros.svh.
`include "assert_macros.svh"
module phc_dp import phc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_cmd,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [CNT_W-1:0]  in_hits,
  input  logic [MASK_W-1:0] in_mask,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [CNT_W-1:0]  out_count,
  output logic [KEY_W-1:0]  out_key,
  output logic [1:0]        out_status
);

  logic [1:0]        cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  hits_r;
  logic [MASK_W-1:0] mask_r;
  logic [OCC_W-1:0]  occ_r;
  scan_mode_t        mode_r;
  logic [OCC_W-1:0]  addr_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  found_idx_r;
  logic [CNT_W-1:0]  found_cnt_r;
  logic              has_best_r;
  logic [CNT_W-1:0]  best_cnt_r;
  logic [KEY_W-1:0]  best_key_r;
  logic [BIT_W-1:0]  bit_r;
  logic [CNT_W-1:0]  prefix_r;
  logic [OCC_W-1:0]  cnt_ge_r;
  logic [CNT_W-1:0]  sum_all_r;
  logic [CNT_W-1:0]  sum_gt_r;
  logic [OCC_W-1:0]  cnt_gt_r;
  logic [CNT_W-1:0]  prod_r;
  logic              add_full_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_count_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [1:0]        out_status_r;

  logic [KEY_W-1:0]  d_key;
  logic [CNT_W-1:0]  d_cnt;
  logic [CNT_W-1:0]  cand;
  logic              not_full;
  logic              issue;
  logic              key_we;
  logic              cnt_we;
  logic [IDX_W-1:0]  w_idx;
  logic [CNT_W-1:0]  w_cnt;
  logic [CNT_W-1:0]  res_count;
  logic [KEY_W-1:0]  res_key;
  logic [1:0]        res_status;

  assign cand     = prefix_r | (CNT_W'(1) << bit_r);
  assign not_full = occ_r < OCC_W'(CAPACITY);
  assign issue    = cmd_i.scan && (addr_r < occ_r) && !(mode_r == MODE_LOOKUP && found_r);

  // Write port: bump a matched count or append a new entry
  assign key_we = cmd_i.add_write && !found_r && not_full;
  assign cnt_we = cmd_i.add_write && (found_r || not_full);
  assign w_idx  = found_r ? found_idx_r : occ_r[IDX_W-1:0];
  assign w_cnt  = found_r ? found_cnt_r + hits_r : hits_r;

  phc_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (w_idx),
    .wdata (key_r),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (d_key)
  );

  phc_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (w_idx),
    .wdata (w_cnt),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (d_cnt)
  );

  // Status back to the controller
  always_comb begin
    sts_o.scan_done = !rd_vld_r && ((addr_r >= occ_r) || (mode_r == MODE_LOOKUP && found_r));
    sts_o.bit_zero  = (bit_r == '0);
    sts_o.sum_over  = CW'(mask_r) > CW'(occ_r);
    sts_o.mask_zero = (mask_r == '0);
    sts_o.cmd       = cmd_r;
    sts_o.out_busy  = out_valid_r && !out_ready;
  end

  // Form the result of the finished item
  always_comb begin
    res_count  = '0;
    res_key    = '0;
    res_status = ST_OK;
    case (cmd_r)
      CMD_ADD: begin
        res_status = add_full_r ? ST_FULL : ST_OK;
      end
      CMD_READ: begin
        res_count = found_r ? found_cnt_r : '0;
      end
      CMD_TOP: begin
        if (occ_r == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_key = best_key_r;
        end
      end
      CMD_SUM: begin
        if (CW'(mask_r) > CW'(occ_r)) begin
          res_count = '0;
        end else if (mask_r == '0) begin
          res_count = sum_all_r;
        end else begin
          res_count = sum_all_r - sum_gt_r - prod_r;
        end
      end
      default: begin
        res_count = '0;
      end
    endcase
  end

  // Item registers, scan engine and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      mode_r      <= MODE_LOOKUP;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      has_best_r  <= 1'b0;
      add_full_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bit_r       <= '0;
    end else begin
      // hold the item
      if (cmd_i.load_item) begin
        cmd_r      <= in_cmd;
        key_r      <= in_key;
        hits_r     <= in_hits;
        mask_r     <= in_mask;
        bit_r      <= BIT_W'(CNT_W - 1);
        prefix_r   <= '0;
        add_full_r <= 1'b0;
      end
      // clear the scan
      if (cmd_i.start) begin
        mode_r     <= cmd_i.mode;
        addr_r     <= '0;
        rd_vld_r   <= 1'b0;
        found_r    <= 1'b0;
        has_best_r <= 1'b0;
        cnt_ge_r   <= '0;
        sum_all_r  <= '0;
        sum_gt_r   <= '0;
        cnt_gt_r   <= '0;
      end else begin
        // advance the read address
        rd_vld_r <= issue;
        rd_idx_r <= addr_r[IDX_W-1:0];
        if (issue) begin
          addr_r <= addr_r + OCC_W'(1);
        end
        // consume the returned entry
        if (rd_vld_r) begin
          case (mode_r)
            MODE_LOOKUP: begin
              if (!found_r && d_key == key_r) begin
                found_r     <= 1'b1;
                found_idx_r <= rd_idx_r;
                found_cnt_r <= d_cnt;
              end
            end
            MODE_TOP: begin
              if (!has_best_r || d_cnt > best_cnt_r) begin
                has_best_r <= 1'b1;
                best_cnt_r <= d_cnt;
                best_key_r <= d_key;
              end
            end
            MODE_GE: begin
              if (d_cnt >= cand) begin
                cnt_ge_r <= cnt_ge_r + OCC_W'(1);
              end
            end
            MODE_FINAL: begin
              sum_all_r <= sum_all_r + d_cnt;
              if (d_cnt > prefix_r) begin
                sum_gt_r <= sum_gt_r + d_cnt;
                cnt_gt_r <= cnt_gt_r + OCC_W'(1);
              end
            end
            default: begin
              found_r <= found_r;
            end
          endcase
        end
      end
      // settle one threshold bit
      if (cmd_i.commit_bit) begin
        if (CW'(cnt_ge_r) >= CW'(mask_r)) begin
          prefix_r <= cand;
        end
        bit_r <= bit_r - BIT_W'(1);
      end
      // grow the table on a new key
      if (cmd_i.add_write) begin
        if (!found_r) begin
          if (not_full) begin
            occ_r <= occ_r + OCC_W'(1);
          end else begin
            add_full_r <= 1'b1;
          end
        end
      end
      // drop the output once taken, load a new one
      if (cmd_i.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Tie correction product and output payload
  always_ff @(posedge clk) begin
    if (cmd_i.mul) begin
      prod_r <= CNT_W'(CW'(mask_r) - CW'(cnt_gt_r)) * prefix_r;
    end
    if (cmd_i.finish) begin
      out_count_r  <= res_count;
      out_key_r    <= res_key;
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_count  = out_count_r;
  assign out_key    = out_key_r;
  assign out_status = out_status_r;

  `PHC_ASSERT(a_occ_bound, clk, rst_n, occ_r <= OCC_W'(CAPACITY))
  `PHC_ASSERT(a_found_idx, clk, rst_n, !found_r || (OCC_W'(found_idx_r) < occ_r))
  `PHC_ASSERT_NEXT(a_occ_inc, clk, rst_n, key_we, occ_r == $past(occ_r) + OCC_W'(1))
  `PHC_ASSERT(a_rd_range, clk, rst_n, !rd_vld_r || (OCC_W'(rd_idx_r) < occ_r))

endmodule

// File: rtl/core/phc_ctrl.sv
// Controller of the hit-count table: sequences scans, threshold passes and output.
// Depends on phc_pkg.
module phc_ctrl import phc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOOK,
    S_TOP,
    S_GE,
    S_FINAL,
    S_ADD_WR,
    S_MUL_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   done_wait;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd_o     = '0;
    cmd_o.mode = MODE_LOOKUP;
    state_nxt = state_r;
    done_wait = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load_item = 1'b1;
          state_nxt       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          CMD_ADD, CMD_READ: begin
            cmd_o.start = 1'b1;
            cmd_o.mode  = MODE_LOOKUP;
            state_nxt   = S_LOOK;
          end
          CMD_TOP: begin
            cmd_o.start = 1'b1;
            cmd_o.mode  = MODE_TOP;
            state_nxt   = S_TOP;
          end
          default: begin
            if (sts_i.sum_over) begin
              done_wait = 1'b1;
            end else if (sts_i.mask_zero) begin
              cmd_o.start = 1'b1;
              cmd_o.mode  = MODE_FINAL;
              state_nxt   = S_FINAL;
            end else begin
              cmd_o.start = 1'b1;
              cmd_o.mode  = MODE_GE;
              state_nxt   = S_GE;
            end
          end
        endcase
      end
      S_LOOK: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.cmd == CMD_ADD) begin
            state_nxt = S_ADD_WR;
          end else begin
            done_wait = 1'b1;
          end
        end
      end
      S_TOP: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          done_wait = 1'b1;
        end
      end
      S_GE: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.commit_bit = 1'b1;
          cmd_o.start      = 1'b1;
          cmd_o.mode       = sts_i.bit_zero ? MODE_FINAL : MODE_GE;
          state_nxt        = sts_i.bit_zero ? S_FINAL : S_GE;
        end
      end
      S_FINAL: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.mul = 1'b1;
          state_nxt = S_MUL_DONE;
        end
      end
      S_ADD_WR: begin
        cmd_o.add_write = 1'b1;
        state_nxt       = S_MUL_DONE;
      end
      S_MUL_DONE: begin
        done_wait = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // hand the result over once the output register is free
    if (done_wait) begin
      if (!sts_i.out_busy) begin
        cmd_o.finish = 1'b1;
        state_nxt    = S_IDLE;
      end else begin
        state_nxt = S_MUL_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/pixel_hit_count_table.sv
// Pixel hit-count table, one item at a time. Read and top scan the n stored entries;
// add scans the keys at one RAM read per cycle, then writes. A masked sum runs 32
// threshold passes and a summing pass, a zero mask only the summing pass, and a mask
// that exceeds n gives its result with no scan.
// The next item is taken in the cycle after the result is loaded; a waiting result holds it.
// Synchronous active-low reset empties the table at once; no clearing pass.
module pixel_hit_count_table import phc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  phc_in_if.sink     in_item,
  phc_out_if.source  out_item
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  phc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .sts_i    (dp_sts),
    .cmd_o    (dp_cmd)
  );

  phc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_item.cmd),
    .in_key     (in_item.pixel_key),
    .in_hits    (in_item.hit_count),
    .in_mask    (in_item.mask_count),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_ready  (out_item.ready),
    .out_valid  (out_item.valid),
    .out_count  (out_item.count_out),
    .out_key    (out_item.key_out),
    .out_status (out_item.status)
  );

endmodule
